>>> rtl/lss_pkg.sv
// Shared types and constants for the LIFO stack with search
package lss_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_PUSH    = 2'd0,
		MODE_POP     = 2'd1,
		MODE_DISPLAY = 2'd2,
		MODE_SEARCH  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISP,
		S_SRCH
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     wrap;
	} cell_ctl_t;

endpackage

>>> rtl/lss_cell.sv
// One stack cell: holds a word, shifts it towards or away from the top, or rotates
module lss_cell (
	input  logic                                clk,
	input  lss_pkg::cell_ctl_t                  ctl,
	input  logic signed [lss_pkg::DATA_W-1:0]   upper,
	input  logic signed [lss_pkg::DATA_W-1:0]   lower,
	input  logic signed [lss_pkg::DATA_W-1:0]   top,
	output logic signed [lss_pkg::DATA_W-1:0]   word
);

	logic signed [lss_pkg::DATA_W-1:0] word_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			lss_pkg::CELL_HOLD: word_q <= word_q;
			lss_pkg::CELL_PUSH: word_q <= upper;
			lss_pkg::CELL_POP:  word_q <= lower;
			lss_pkg::CELL_ROT:  word_q <= ctl.wrap ? top : lower;
		endcase
	end

	assign word = word_q;

endmodule

>>> rtl/lifo_stack_with_search.sv
// LIFO stack with search: push and pop shift the cell chain; display and search rotate it.
// Push, pop and any request on an empty stack: one result, registered, in the cycle after the request.
// Display of n entries: busy while the entries rotate through the top cell, one result a cycle.
// Search of n entries: one compare at the top cell a cycle while busy, then one result.
// The receiver cannot stall; each result is shown for one cycle with valid high.
// Reset clears the entry count and control state; the stored words stay undefined until pushed.
module lifo_stack_with_search #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          mode,
	input  logic signed [lss_pkg::DATA_W-1:0]   value,
	output logic                                valid,
	output logic [1:0]                          status,
	output logic                                found,
	output logic signed [lss_pkg::DATA_W-1:0]   data,
	output logic                                last
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	lss_pkg::state_t                    state_q, state_n;
	logic [CW-1:0]                      count_q, count_n;
	logic [CW-1:0]                      left_q, left_n;
	logic                               hit_q, hit_n;
	logic signed [lss_pkg::DATA_W-1:0]  key_q;
	lss_pkg::cell_op_t                  cell_op;
	logic                               accept;
	logic                               match;

	logic                               emit;
	lss_pkg::status_t                   status_n;
	logic                               found_n;
	logic signed [lss_pkg::DATA_W-1:0]  data_n;
	logic                               last_n;

	logic                               valid_q;
	lss_pkg::status_t                   status_q;
	logic                               found_q;
	logic signed [lss_pkg::DATA_W-1:0]  data_q;
	logic                               last_q;

	logic signed [lss_pkg::DATA_W-1:0]  word_w [DEPTH];
	lss_pkg::cell_ctl_t                 ctl_w  [DEPTH];

	// cell 0 is the top of the stack
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [lss_pkg::DATA_W-1:0] upper_w;
		logic signed [lss_pkg::DATA_W-1:0] lower_w;

		if (g == 0) begin : g_top
			assign upper_w = value;
		end else begin : g_mid
			assign upper_w = word_w[g-1];
		end

		if (g == DEPTH - 1) begin : g_bot
			assign lower_w = '0;
		end else begin : g_up
			assign lower_w = word_w[g+1];
		end

		assign ctl_w[g].op   = cell_op;
		assign ctl_w[g].wrap = (count_q == CW'(g + 1));

		lss_cell u_cell (
			.clk   (clk),
			.ctl   (ctl_w[g]),
			.upper (upper_w),
			.lower (lower_w),
			.top   (word_w[0]),
			.word  (word_w[g])
		);
	end

	assign busy   = (state_q != lss_pkg::S_IDLE);
	assign accept = start && !busy;
	assign match  = hit_q || (word_w[0] == key_q);

	always_comb begin
		state_n  = state_q;
		count_n  = count_q;
		left_n   = left_q;
		hit_n    = hit_q;
		cell_op  = lss_pkg::CELL_HOLD;
		emit     = 1'b0;
		status_n = lss_pkg::ST_OK;
		found_n  = 1'b0;
		data_n   = '0;
		last_n   = 1'b1;
		unique case (state_q)
			lss_pkg::S_IDLE: begin
				if (accept) begin
					unique case (lss_pkg::mode_t'(mode))
						lss_pkg::MODE_PUSH: begin
							emit = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								status_n = lss_pkg::ST_FULL;
							end else begin
								cell_op = lss_pkg::CELL_PUSH;
								count_n = count_q + CW'(1);
							end
						end
						lss_pkg::MODE_POP: begin
							emit = 1'b1;
							if (count_q == '0) begin
								status_n = lss_pkg::ST_EMPTY;
							end else begin
								cell_op = lss_pkg::CELL_POP;
								count_n = count_q - CW'(1);
							end
						end
						lss_pkg::MODE_DISPLAY: begin
							if (count_q == '0) begin
								emit     = 1'b1;
								status_n = lss_pkg::ST_EMPTY;
							end else begin
								left_n  = count_q;
								state_n = lss_pkg::S_DISP;
							end
						end
						lss_pkg::MODE_SEARCH: begin
							if (count_q == '0) begin
								emit     = 1'b1;
								status_n = lss_pkg::ST_EMPTY;
							end else begin
								left_n  = count_q;
								hit_n   = 1'b0;
								state_n = lss_pkg::S_SRCH;
							end
						end
					endcase
				end
			end
			lss_pkg::S_DISP: begin
				emit    = 1'b1;
				data_n  = word_w[0];
				last_n  = (left_q == CW'(1));
				cell_op = lss_pkg::CELL_ROT;
				left_n  = left_q - CW'(1);
				if (left_q == CW'(1)) begin
					state_n = lss_pkg::S_IDLE;
				end
			end
			lss_pkg::S_SRCH: begin
				cell_op = lss_pkg::CELL_ROT;
				left_n  = left_q - CW'(1);
				hit_n   = match;
				if (left_q == CW'(1)) begin
					emit    = 1'b1;
					found_n = match;
					state_n = lss_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = lss_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lss_pkg::S_IDLE;
			count_q <= '0;
			left_q  <= '0;
			hit_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			left_q  <= left_n;
			hit_q   <= hit_n;
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= value;
		end
		status_q <= status_n;
		found_q  <= found_n;
		data_q   <= data_n;
		last_q   <= last_n;
	end

	assign valid  = valid_q;
	assign status = status_q;
	assign found  = found_q;
	assign data   = data_q;
	assign last   = last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode == lss_pkg::MODE_PUSH) && (count_q == CW'(DEPTH))
		|=> valid && (status == lss_pkg::ST_FULL) && $stable(count_q))
		else $error("push to full stack not refused");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ((mode == lss_pkg::MODE_PUSH) || (mode == lss_pkg::MODE_POP))
		|=> valid && last)
		else $error("push or pop result missing");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> !busy)
		else $error("final result while still busy");

endmodule

>>> dv/lifo_stack_with_search_test.sv
// Self-checking testbench for the LIFO stack with search: directed and random requests.
module lifo_stack_with_search_test;

	localparam int unsigned DEPTH     = 16;
	localparam int unsigned N_RANDOM  = 104;

	typedef struct {
		lss_pkg::status_t   status;
		logic               found;
		logic signed [31:0] data;
		logic               last;
	} stack_result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic               busy;
	logic [1:0]         mode   = lss_pkg::MODE_PUSH;
	logic signed [31:0] value  = '0;
	logic               valid;
	logic [1:0]         status;
	logic               found;
	logic signed [31:0] data;
	logic               last;

	lifo_stack_with_search #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.mode   (mode),
		.value  (value),
		.valid  (valid),
		.status (status),
		.found  (found),
		.data   (data),
		.last   (last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// shadow stack
	logic signed [31:0] held_words [DEPTH];
	int unsigned        held_count = 0;
	stack_result_t      awaited_results [$];
	stack_result_t      next_awaited;

	int unsigned n_requests = 0;
	int unsigned n_results  = 0;
	int unsigned n_full     = 0;
	int unsigned n_empty    = 0;
	int unsigned n_hits     = 0;
	int unsigned n_shown    = 0;
	int unsigned mismatches = 0;
	int unsigned no_idle_left = 0;

	task automatic add_result(lss_pkg::status_t st, logic fnd, logic signed [31:0] d,
			logic lst);
		stack_result_t r;
		r.status = st;
		r.found  = fnd;
		r.data   = d;
		r.last   = lst;
		awaited_results.push_back(r);
	endtask

	task automatic predict_stack(lss_pkg::mode_t m, logic signed [31:0] v);
		logic hit;
		hit = 1'b0;
		if (m == lss_pkg::MODE_PUSH) begin
			if (held_count >= DEPTH) begin
				add_result(lss_pkg::ST_FULL, 1'b0, '0, 1'b1);
				n_full++;
			end else begin
				held_words[held_count] = v;
				held_count++;
				add_result(lss_pkg::ST_OK, 1'b0, '0, 1'b1);
			end
		end else if (held_count == 0) begin
			add_result(lss_pkg::ST_EMPTY, 1'b0, '0, 1'b1);
			n_empty++;
		end else if (m == lss_pkg::MODE_POP) begin
			held_count--;
			add_result(lss_pkg::ST_OK, 1'b0, '0, 1'b1);
		end else if (m == lss_pkg::MODE_DISPLAY) begin
			for (int i = held_count; i > 0; i--)
				add_result(lss_pkg::ST_OK, 1'b0, held_words[i-1], (i == 1));
			n_shown += held_count;
		end else begin
			for (int i = 0; i < held_count; i++)
				if (held_words[i] === v)
					hit = 1'b1;
			add_result(lss_pkg::ST_OK, hit, '0, 1'b1);
			if (hit)
				n_hits++;
		end
	endtask

	// one request; start is left high so a back-to-back request need not lower it first
	task automatic issue_request(lss_pkg::mode_t m, logic signed [31:0] v);
		int unsigned gap;
		if (no_idle_left > 0) begin
			gap = 0;
			no_idle_left--;
		end else begin
			gap = $urandom_range(0, 15);
			if ($urandom_range(0, 19) == 0)
				no_idle_left = $urandom_range(5, 20);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode  <= m;
		value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		n_requests++;
		predict_stack(m, v);
	endtask

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: got status %0d found %0b data %0h last %0b", $time, what,
				status, found, data, last);
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ($isunknown(valid)) begin
				report_mismatch("valid unknown");
			end else if (valid) begin
				n_results++;
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result");
				end else begin
					next_awaited = awaited_results.pop_front();
					if (status !== next_awaited.status || found !== next_awaited.found ||
							data !== next_awaited.data || last !== next_awaited.last) begin
						report_mismatch("mismatch");
						if (mismatches <= 10)
							$display("    expected status %0d found %0b data %0h last %0b",
								next_awaited.status, next_awaited.found,
								next_awaited.data, next_awaited.last);
					end
				end
			end
		end
	end

	task automatic test_empty_stack();
		issue_request(lss_pkg::MODE_POP, 32'h1234_5678);
		issue_request(lss_pkg::MODE_DISPLAY, '0);
		issue_request(lss_pkg::MODE_SEARCH, '0);
	endtask

	task automatic test_extreme_words();
		issue_request(lss_pkg::MODE_PUSH, 32'sh8000_0000);
		issue_request(lss_pkg::MODE_PUSH, 32'sh7fff_ffff);
		issue_request(lss_pkg::MODE_PUSH, 32'sh5555_5555);
		issue_request(lss_pkg::MODE_PUSH, 32'shaaaa_aaaa);
		issue_request(lss_pkg::MODE_SEARCH, 32'sh7fff_ffff);
		issue_request(lss_pkg::MODE_SEARCH, 32'sh0000_0001);
		issue_request(lss_pkg::MODE_DISPLAY, 32'shffff_ffff);
		issue_request(lss_pkg::MODE_POP, '0);
	endtask

	task automatic test_full_stack();
		issue_request(lss_pkg::MODE_PUSH, 32'sh7fff_ffff);
		while (held_count < DEPTH)
			issue_request(lss_pkg::MODE_PUSH, $urandom);
		issue_request(lss_pkg::MODE_PUSH, 32'shffff_ffff);
		issue_request(lss_pkg::MODE_DISPLAY, '0);
		issue_request(lss_pkg::MODE_SEARCH, 32'sh8000_0000);
	endtask

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_random_traffic();
		int unsigned push_weight;
		int unsigned roll;
		logic signed [31:0] w;
		push_weight = 50;
		for (int n = 0; n < N_RANDOM; n++) begin
			// swing between filling and draining so both ends are reached
			if (n % 20 == 0)
				push_weight = $urandom_range(0, 1) ? 75 : 25;
			roll = $urandom_range(0, 99);
			if (roll < push_weight) begin
				issue_request(lss_pkg::MODE_PUSH, pick_word());
			end else if (roll < push_weight + (100 - push_weight) / 2) begin
				issue_request(lss_pkg::MODE_POP, $urandom);
			end else if (roll < push_weight + 3 * (100 - push_weight) / 4) begin
				if (held_count > 0 && $urandom_range(0, 1))
					w = held_words[$urandom_range(0, held_count - 1)];
				else
					w = pick_word();
				issue_request(lss_pkg::MODE_SEARCH, w);
			end else begin
				issue_request(lss_pkg::MODE_DISPLAY, $urandom);
			end
		end
	endtask

	initial begin
		#1000000;
		$display("lifo_stack_with_search_test: FAIL");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_stack();
		test_extreme_words();
		test_full_stack();
		test_random_traffic();
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);
		$display("%0d requests, %0d results, %0d display entries checked", n_requests,
			n_results, n_shown);
		$display("%0d refused pushes, %0d empty-stack requests, %0d search hits", n_full,
			n_empty, n_hits);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("lifo_stack_with_search_test: PASS");
		end else begin
			$display("%0d failures", mismatches);
			$display("lifo_stack_with_search_test: FAIL");
		end
		$finish;
	end

endmodule

>>> lifo_stack_with_search.f
rtl/lss_pkg.sv
rtl/lss_cell.sv
rtl/lifo_stack_with_search.sv
dv/lifo_stack_with_search_test.sv
